[hdl/dth_pkg.sv]
`timescale 1ns / 1ps

package dth_pkg;

  localparam int HeapDepthDef = 64;
  localparam int IdCountDef   = 64;
  localparam int TimeBitsDef  = 48;

  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int ID_W    = 6;
  localparam int DL_W    = 48;
  localparam int GEN_W   = 16;
  localparam int TAG_W   = 8;
  localparam int SEQ_W   = 32;
  localparam int ALLOW_W = 16;
  localparam int MAX_RESULTS = 64;
  localparam int NF_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [ALLOW_W-1:0] EARLY_RESET = 16'd10;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DL_W-1:0]  dl;
    logic [GEN_W-1:0] gen;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  typedef enum logic [1:0] {
    OUT_STATUS    = 2'd0,
    OUT_FIRE      = 2'd1,
    OUT_FIRE_LAST = 2'd2
  } out_kind_t;

  typedef struct packed {
    logic      take;
    logic      cancel_mark;
    logic      tag_rd_in;
    logic      add_init;
    logic      add_step;
    logic      add_put;
    logic      top_rd;
    logic      top_cap;
    logic      top_retire;
    logic      pop;
    logic      pop_last;
    logic      sd_rd;
    logic      sd_step;
    logic      sd_put;
    logic      fire_take;
    logic      tick_clear;
    logic      out_load;
    out_kind_t out_kind;
    logic [ST_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic full;
    logic pend_id;
    logic empty;
    logic add_root;
    logic up_move;
    logic up_top;
    logic top_cancel;
    logic top_due;
    logic pop_empty;
    logic sd_leaf;
    logic sd_move;
    logic have_fire;
  } stat_t;

  // a before b: earlier deadline, then earlier insertion by wrapped sequence
  function automatic logic earlier(entry_t a, entry_t b);
    logic [SEQ_W-1:0] d;
    d = a.seq - b.seq;
    if (a.dl != b.dl) return a.dl < b.dl;
    return d[SEQ_W-1];
  endfunction

endpackage

[hdl/dth_ctrl.sv]
`timescale 1ns / 1ps

module dth_ctrl import dth_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  logic  out_free,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_DISPATCH = 16'h0002,
    S_ADD_INIT = 16'h0004,
    S_ADD_CMP  = 16'h0008,
    S_ADD_PUT  = 16'h0010,
    S_RESP     = 16'h0020,
    S_TOP_RD   = 16'h0040,
    S_TOP_TAG  = 16'h0080,
    S_TOP_CHK  = 16'h0100,
    S_FIRE     = 16'h0200,
    S_POP      = 16'h0400,
    S_POP_LAST = 16'h0800,
    S_SD_RD    = 16'h1000,
    S_SD_CMP   = 16'h2000,
    S_SD_PUT   = 16'h4000,
    S_TICK_END = 16'h8000
  } state_t;

  state_t          state_r, state_nxt;
  logic [ST_W-1:0] resp_r, resp_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    cmd.out_kind   = OUT_STATUS;
    cmd.out_status = resp_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_ADD: begin
            if (stat.full) begin
              resp_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.tag_rd_in = 1'b1;
              state_nxt     = S_ADD_INIT;
            end
          end
          OP_CANCEL: begin
            cmd.cancel_mark = 1'b1;
            resp_nxt        = stat.pend_id ? ST_OK : ST_NOTFOUND;
            state_nxt       = S_RESP;
          end
          OP_TICK: state_nxt = S_TOP_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADD_INIT: begin
        cmd.add_init = 1'b1;
        state_nxt    = stat.add_root ? S_ADD_PUT : S_ADD_CMP;
      end
      S_ADD_CMP: begin
        cmd.add_step = 1'b1;
        state_nxt    = (stat.up_move && !stat.up_top) ? S_ADD_CMP : S_ADD_PUT;
      end
      S_ADD_PUT: begin
        cmd.add_put = 1'b1;
        resp_nxt    = ST_OK;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TOP_RD: begin
        if (stat.empty) begin
          state_nxt = S_TICK_END;
        end else begin
          cmd.top_rd = 1'b1;
          state_nxt  = S_TOP_TAG;
        end
      end
      S_TOP_TAG: begin
        cmd.top_cap = 1'b1;
        state_nxt   = S_TOP_CHK;
      end
      S_TOP_CHK: begin
        if (stat.top_cancel) begin
          cmd.top_retire = 1'b1;
          state_nxt      = S_POP;
        end else if (stat.top_due) begin
          cmd.top_retire = 1'b1;
          state_nxt      = S_FIRE;
        end else begin
          state_nxt = S_TICK_END;
        end
      end
      S_FIRE: begin
        // hold the previous firing until now: it is known not to be the last
        if (out_free || !stat.have_fire) begin
          cmd.out_load  = stat.have_fire;
          cmd.out_kind  = OUT_FIRE;
          cmd.fire_take = 1'b1;
          state_nxt     = S_POP;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = stat.pop_empty ? S_TOP_RD : S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.pop_last = 1'b1;
        state_nxt    = S_SD_RD;
      end
      S_SD_RD: begin
        cmd.sd_rd = 1'b1;
        state_nxt = stat.sd_leaf ? S_SD_PUT : S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.sd_step = 1'b1;
        state_nxt   = stat.sd_move ? S_SD_RD : S_SD_PUT;
      end
      S_SD_PUT: begin
        cmd.sd_put = 1'b1;
        state_nxt  = S_TOP_RD;
      end
      S_TICK_END: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = stat.have_fire ? OUT_FIRE_LAST : OUT_STATUS;
          cmd.out_status = ST_NONE;
          cmd.tick_clear = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/dth_datapath.sv]
`timescale 1ns / 1ps

module dth_datapath import dth_pkg::*; #(
  parameter int HEAP_DEPTH = HeapDepthDef,
  parameter int ID_COUNT   = IdCountDef,
  parameter int TIME_BITS  = TimeBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [OP_W-1:0]    in_op,
  input  logic [ID_W-1:0]    in_id,
  input  logic [DL_W-1:0]    in_dl,
  input  logic [GEN_W-1:0]   in_gen,
  input  logic [DL_W-1:0]    in_now,
  input  logic [ALLOW_W-1:0] allow,
  output stat_t              stat,
  output entry_t             fire
);

  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int KID_W = CNT_W + 1;
  localparam int IDC_W = $clog2(ID_COUNT);
  localparam int ID_VALS = 1 << ID_W;
  localparam logic [DL_W-1:0] TimeMask =
    (TIME_BITS >= DL_W) ? {DL_W{1'b1}} : DL_W'((64'd1 << TIME_BITS) - 64'd1);

  logic [IDC_W-1:0] id_mod [ID_VALS];
  for (genvar g = 0; g < ID_VALS; g++) begin : g_idmod
    assign id_mod[g] = IDC_W'(g % ID_COUNT);
  end

  entry_t heap_mem [HEAP_DEPTH];
  logic [TAG_W-1:0] tag_mem [ID_COUNT];

  logic [OP_W-1:0]   op_r;
  logic [IDC_W-1:0]  idm_r;
  logic [DL_W-1:0]   dl_r, now_r;
  logic [GEN_W-1:0]  gen_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [IDX_W-1:0]  pos_r;
  logic              rok_r;
  entry_t            mv_r, top_r, fire_r, rd_a_r, rd_b_r;
  logic              have_r;
  logic [NF_W-1:0]   nf_r;
  logic [ID_COUNT-1:0] pend_r, canc_r, tvld_r;
  logic [TAG_W-1:0]  tag_rd_r;
  logic              tag_rv_r;

  logic [IDX_W-1:0] par, cnt_par, ra_addr, hw_addr;
  logic [KID_W-1:0] lw, rw;
  logic             ra_en, hw_en;
  entry_t           hw_data, first, m, new_e;
  logic             cand_l, pick_r;
  logic [TAG_W-1:0] tag_now;
  logic [IDC_W-1:0] tid;
  logic             latest;
  logic [DL_W:0]    due_lim;

  assign par     = IDX_W'((pos_r - IDX_W'(1)) >> 1);
  assign cnt_par = IDX_W'((cnt_r - CNT_W'(1)) >> 1);
  assign lw      = KID_W'({pos_r, 1'b1});
  assign rw      = lw + KID_W'(1);

  assign cand_l  = earlier(rd_a_r, mv_r);
  assign first   = cand_l ? rd_a_r : mv_r;
  assign pick_r  = rok_r && earlier(rd_b_r, first);
  assign m       = pick_r ? rd_b_r : first;

  assign tag_now = tag_rv_r ? tag_rd_r : '0;
  assign tid     = IDC_W'(top_r.id);
  assign latest  = (tag_now == top_r.tag);
  assign due_lim = {1'b0, now_r} + (DL_W + 1)'(allow);

  always_comb begin
    new_e.id  = ID_W'(idm_r);
    new_e.dl  = dl_r;
    new_e.gen = gen_r;
    new_e.tag = tag_now + TAG_W'(1);
    new_e.seq = seq_r;
  end

  always_comb begin
    ra_en   = 1'b1;
    ra_addr = '0;
    if (cmd.add_init)      ra_addr = cnt_par;
    else if (cmd.add_step) ra_addr = IDX_W'((par - IDX_W'(1)) >> 1);
    else if (cmd.pop)      ra_addr = IDX_W'(cnt_r - CNT_W'(1));
    else if (cmd.sd_rd)    ra_addr = IDX_W'(lw);
    else                   ra_en   = cmd.top_rd;
  end

  always_comb begin
    hw_addr = pos_r;
    hw_data = mv_r;
    hw_en   = cmd.add_put || cmd.sd_put;
    if (cmd.add_step && earlier(mv_r, rd_a_r)) begin
      hw_en   = 1'b1;
      hw_data = rd_a_r;
    end else if (cmd.sd_step && (cand_l || pick_r)) begin
      hw_en   = 1'b1;
      hw_data = m;
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    if (ra_en) rd_a_r <= heap_mem[ra_addr];
    if (cmd.sd_rd) rd_b_r <= heap_mem[IDX_W'(rw)];
  end

  always_ff @(posedge clk) begin
    if (cmd.add_init) tag_mem[idm_r] <= new_e.tag;
    if (cmd.tag_rd_in) begin
      tag_rd_r <= tag_mem[idm_r];
      tag_rv_r <= tvld_r[idm_r];
    end else if (cmd.top_cap) begin
      tag_rd_r <= tag_mem[IDC_W'(rd_a_r.id)];
      tag_rv_r <= tvld_r[IDC_W'(rd_a_r.id)];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= in_op;
      idm_r <= id_mod[in_id];
      dl_r  <= in_dl & TimeMask;
      gen_r <= in_gen;
      now_r <= in_now & TimeMask;
    end
    if (cmd.add_init) begin
      mv_r  <= new_e;
      pos_r <= IDX_W'(cnt_r);
    end
    if (cmd.add_step && earlier(mv_r, rd_a_r)) pos_r <= par;
    if (cmd.top_cap) top_r <= rd_a_r;
    if (cmd.pop_last) begin
      mv_r  <= rd_a_r;
      pos_r <= '0;
    end
    if (cmd.sd_rd) rok_r <= (rw < KID_W'(cnt_r));
    if (cmd.sd_step && (cand_l || pick_r)) pos_r <= pick_r ? IDX_W'(rw) : IDX_W'(lw);
    if (cmd.fire_take) fire_r <= top_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seq_r  <= '0;
      pend_r <= '0;
      canc_r <= '0;
      tvld_r <= '0;
      have_r <= 1'b0;
      nf_r   <= '0;
    end else begin
      if (cmd.add_init) begin
        cnt_r         <= cnt_r + CNT_W'(1);
        seq_r         <= seq_r + SEQ_W'(1);
        tvld_r[idm_r] <= 1'b1;
        pend_r[idm_r] <= 1'b1;
        canc_r[idm_r] <= 1'b0;
      end
      if (cmd.cancel_mark && pend_r[idm_r]) canc_r[idm_r] <= 1'b1;
      if (cmd.top_retire && latest) begin
        pend_r[tid] <= 1'b0;
        canc_r[tid] <= 1'b0;
      end
      if (cmd.pop) cnt_r <= cnt_r - CNT_W'(1);
      if (cmd.fire_take) begin
        have_r <= 1'b1;
        nf_r   <= nf_r + NF_W'(1);
      end
      if (cmd.tick_clear) begin
        have_r <= 1'b0;
        nf_r   <= '0;
      end
    end
  end

  always_comb begin
    stat.op         = op_r;
    stat.full       = (cnt_r == CNT_W'(HEAP_DEPTH));
    stat.pend_id    = pend_r[idm_r];
    stat.empty      = (cnt_r == '0);
    stat.add_root   = (cnt_r == '0);
    stat.up_move    = earlier(mv_r, rd_a_r);
    stat.up_top     = (par == '0);
    stat.top_cancel = latest && canc_r[tid];
    stat.top_due    = ({1'b0, top_r.dl} <= due_lim) && (nf_r < NF_W'(MAX_RESULTS));
    stat.pop_empty  = (cnt_r == CNT_W'(1));
    stat.sd_leaf    = (lw >= KID_W'(cnt_r));
    stat.sd_move    = cand_l || pick_r;
    stat.have_fire  = have_r;
  end

  assign fire = fire_r;

endmodule

[hdl/deadline_timer_heap.sv]
`timescale 1ns / 1ps

// Timer queue kept as a binary min-heap in a single-write, dual-read memory,
// ordered by deadline and then by insertion order. in_tuser selects the
// operation (add, cancel, tick); each add, cancel or tick returns one or more
// transactions, the final one with out_tlast, and the unused code returns
// none. The block takes one item at a time. An add climbs the heap with one
// memory read per level; a tick inspects the top repeatedly and sifts down
// after each removed entry (fired or cancelled). A tick fires at most 64
// timers; the rest wait for the next tick. No clearing pass is needed after
// reset.
module deadline_timer_heap import dth_pkg::*; #(
  parameter int HEAP_DEPTH = HeapDepthDef,
  parameter int ID_COUNT   = IdCountDef,
  parameter int TIME_BITS  = TimeBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // timer_id, deadline, generation, now_time, pad
  input  logic [1:0]   in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // fired_id, fired_generation, fired_deadline, pad
  output logic [1:0]   out_tuser,  // status
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data // early_allowance
);

  cmd_t   cmd;
  stat_t  stat;
  entry_t fire;
  logic   out_free;

  logic [ALLOW_W-1:0] allow_r;
  logic               out_valid_r;
  logic [ST_W-1:0]    out_st_r;
  logic [ID_W-1:0]    out_id_r;
  logic [GEN_W-1:0]   out_gen_r;
  logic [DL_W-1:0]    out_dl_r;
  logic               out_last_r;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) allow_r <= EARLY_RESET;
    else if (cfg_wr_en) allow_r <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_kind == OUT_STATUS) begin
        out_st_r   <= cmd.out_status;
        out_id_r   <= '0;
        out_gen_r  <= '0;
        out_dl_r   <= '0;
        out_last_r <= 1'b1;
      end else begin
        out_st_r   <= ST_OK;
        out_id_r   <= fire.id;
        out_gen_r  <= fire.gen;
        out_dl_r   <= fire.dl;
        out_last_r <= (cmd.out_kind == OUT_FIRE_LAST);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_dl_r, out_gen_r, out_id_r};

  dth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  dth_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_COUNT   (ID_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .in_op  (in_tuser),
    .in_id  (in_tdata[5:0]),
    .in_dl  (in_tdata[53:6]),
    .in_gen (in_tdata[69:54]),
    .in_now (in_tdata[117:70]),
    .allow  (allow_r),
    .stat   (stat),
    .fire   (fire)
  );

endmodule

[dv/tb_deadline_timer_heap.sv]
`timescale 1ns / 1ps

module tb_deadline_timer_heap;
  import dth_pkg::*;

  localparam int SLOTS = 64;
  localparam int IDS = 64;
  localparam logic [DL_W-1:0] TIME_MAX = {DL_W{1'b1}};
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    logic [DL_W-1:0]  dl;
    logic             last;
  } timer_result_t;

  class timer_heap_scoreboard;
    entry_t          heap[SLOTS];
    int unsigned     count;
    logic [SEQ_W-1:0] seq_ctr;
    logic [TAG_W-1:0] tag_of[IDS];
    bit              cancelled[IDS];
    bit              pending[IDS];
    logic [ALLOW_W-1:0] allowance;
    timer_result_t   pending_results[$];
    int              errors;

    function void reset_state();
      count = 0;
      seq_ctr = '0;
      allowance = EARLY_RESET;
      errors = 0;
      for (int i = 0; i < IDS; i++) begin
        tag_of[i] = '0;
        cancelled[i] = 0;
        pending[i] = 0;
      end
    endfunction

    function bit precedes(int a, int b);
      logic [SEQ_W-1:0] diff;
      diff = heap[a].seq - heap[b].seq;
      if (heap[a].dl != heap[b].dl) return heap[a].dl < heap[b].dl;
      return diff[SEQ_W-1];
    endfunction

    function void swap_slots(int a, int b);
      entry_t t;
      t = heap[a];
      heap[a] = heap[b];
      heap[b] = t;
    endfunction

    function void sift_down(int i);
      int l, r, m;
      forever begin
        l = 2 * i + 1;
        r = l + 1;
        m = i;
        if (l < count && precedes(l, m)) m = l;
        if (r < count && precedes(r, m)) m = r;
        if (m == i) break;
        swap_slots(i, m);
        i = m;
      end
    endfunction

    function bit top_is_latest();
      return heap[0].tag == tag_of[heap[0].id];
    endfunction

    function void pop_top();
      if (top_is_latest()) begin
        pending[heap[0].id] = 0;
        cancelled[heap[0].id] = 0;
      end
      count--;
      if (count > 0) begin
        swap_slots(0, count);
        sift_down(0);
      end
    endfunction

    function void drop_cancelled();
      while (count > 0 && top_is_latest() && cancelled[heap[0].id]) pop_top();
    endfunction

    function void push(logic [ST_W-1:0] st, logic [ID_W-1:0] id, logic [GEN_W-1:0] gen,
                       logic [DL_W-1:0] dl, logic last);
      timer_result_t r;
      r.status = st;
      r.id = id;
      r.gen = gen;
      r.dl = dl;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    // note one accepted input transaction and queue what it should produce
    function void note(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                       logic [GEN_W-1:0] gen, logic [DL_W-1:0] now);
      int i, n;
      logic [DL_W-1:0] d;
      if (op == OP_ADD) begin
        if (count >= SLOTS) begin
          push(ST_FULL, '0, '0, '0, 1'b1);
          return;
        end
        tag_of[id] = tag_of[id] + 1'b1;
        pending[id] = 1;
        cancelled[id] = 0;
        i = count;
        heap[i].id = id;
        heap[i].dl = dl;
        heap[i].gen = gen;
        heap[i].tag = tag_of[id];
        heap[i].seq = seq_ctr;
        seq_ctr = seq_ctr + 1'b1;
        count++;
        while (i > 0 && precedes(i, (i - 1) / 2)) begin
          swap_slots(i, (i - 1) / 2);
          i = (i - 1) / 2;
        end
        push(ST_OK, '0, '0, '0, 1'b1);
      end else if (op == OP_CANCEL) begin
        if (!pending[id]) push(ST_NOTFOUND, '0, '0, '0, 1'b1);
        else begin
          cancelled[id] = 1;
          push(ST_OK, '0, '0, '0, 1'b1);
        end
      end else if (op == OP_TICK) begin
        n = 0;
        drop_cancelled();
        while (count > 0 && n < MAX_RESULTS) begin
          d = heap[0].dl;
          if (!(d <= allowance || d - allowance <= now)) break;
          push(ST_OK, heap[0].id, heap[0].gen, d, 1'b0);
          n++;
          pop_top();
          drop_cancelled();
        end
        if (n == 0) push(ST_NONE, '0, '0, '0, 1'b1);
        else pending_results[$].last = 1'b1;
      end
    endfunction

    function void check(logic [ST_W-1:0] st, logic [ID_W-1:0] id, logic [GEN_W-1:0] gen,
                        logic [DL_W-1:0] dl, logic last);
      timer_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%0d gen=%h dl=%h last=%0b",
                 $time, st, id, gen, dl, last);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (e.status !== st || e.id !== id || e.gen !== gen || e.dl !== dl || e.last !== last) begin
        $display("%0t: mismatch expected status=%0d id=%0d gen=%h dl=%h last=%0b",
                 $time, e.status, e.id, e.gen, e.dl, e.last);
        $display("%0t:          actual   status=%0d id=%0d gen=%h dl=%h last=%0b",
                 $time, st, id, gen, dl, last);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en;
  logic [15:0]  cfg_wr_data;

  timer_heap_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;

  deadline_timer_heap DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // check results and stall the result side at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check(out_tuser, out_tdata[5:0], out_tdata[21:6], out_tdata[69:22], out_tlast);
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                      logic [GEN_W-1:0] gen, logic [DL_W-1:0] now);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, now, gen, dl, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note(op, id, dl, gen, now);
  endtask

  // drain, let any silent work finish, then write the allowance
  task automatic set_allowance(logic [ALLOW_W-1:0] value);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.allowance = value;
  endtask

  function automatic logic [DL_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0: return TIME_MAX - DL_W'($urandom_range(0, 100));
      1: return {16'($urandom_range(0, 65535)), $urandom()};
      default: return DL_W'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 63))
                                       : ID_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [GEN_W-1:0] pick_gen();
    return GEN_W'($urandom_range(0, 65535));
  endfunction

  task automatic random_items(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) send(OP_ADD, pick_id(), pick_time(), pick_gen(), '0);
      else if (k < 65) send(OP_CANCEL, pick_id(), '0, '0, '0);
      else if (k < 95) send(OP_TICK, '0, '0, '0, pick_time());
      else begin
        // ignored operation with random content; does not count
        send(OP_IGNORED, pick_id(), pick_time(), pick_gen(), pick_time());
        i--;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    cycle_count = 0;
    send_idle_pct = 29;
    recv_idle_pct = 79;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ADD;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, lazy cancel, ties, empty tick
    send(OP_TICK, '0, '0, '0, '0);
    send(OP_CANCEL, 6'd5, '0, '0, '0);
    send(OP_ADD, 6'd0, '0, '0, '0);
    send(OP_ADD, 6'd63, TIME_MAX, 16'hFFFF, '0);
    send(OP_ADD, 6'd63, 48'd5, 16'h1234, '0);
    send(OP_CANCEL, 6'd63, '0, '0, '0);
    send(OP_CANCEL, 6'd63, '0, '0, '0);
    send(OP_ADD, 6'd1, 48'd100, 16'hAAAA, '0);
    send(OP_ADD, 6'd2, 48'd100, 16'h5555, '0);
    send(OP_ADD, 6'd42, 48'd111, 16'h0F0F, '0);
    send(OP_TICK, '0, '0, '0, '0);
    send(OP_IGNORED, 6'd9, 48'd1, 16'd1, 48'd1);
    send(OP_TICK, '0, '0, '0, 48'd100);
    send(OP_TICK, '0, '0, '0, 48'd101);
    send(OP_TICK, '0, '0, '0, TIME_MAX);
    send(OP_TICK, '0, '0, '0, TIME_MAX);
    send(OP_CANCEL, 6'd63, '0, '0, '0);

    // phase one: zero allowance, fill past full, then drain everything
    set_allowance(16'd0);
    for (int i = 0; i < 66; i++)
      send(OP_ADD, ID_W'($urandom_range(0, 63)), pick_time(), pick_gen(), '0);
    send(OP_TICK, '0, '0, '0, TIME_MAX);
    random_items(60);

    set_allowance(16'hFFFF);
    send_idle_pct = 79;
    recv_idle_pct = 29;
    random_items(60);

    set_allowance(ALLOW_W'($urandom_range(1, 3000)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(60);
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
